// ----- rtl/core/tstw_pkg.sv -----
// Shared types and constants for the touch stroke to wavetable block.
package tstw_pkg;

    typedef enum logic [2:0] {
        OP_FIRST   = 3'd0,
        OP_SECOND  = 3'd1,
        OP_PRESS   = 3'd2,
        OP_RELEASE = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_P4,
        ST_P5,
        ST_RD,
        ST_REL_RD,
        ST_REL_GOT,
        ST_KEEP,
        ST_DIV,
        ST_DRAW,
        ST_REL_DONE
    } state_t;

    localparam logic [11:0] AXIS_MIN  = 12'd160;
    localparam logic [11:0] AXIS_MAX  = 12'd3860;
    localparam logic [16:0] RECIP_185 = 17'd90687;   // floor(2^24/185)
    localparam logic [17:0] RECIP_5   = 18'd209715;  // floor(2^20/5)
    localparam logic [16:0] DIV_185   = 17'd185;
    localparam logic [18:0] DIV_5     = 19'd5;
    localparam logic [8:0]  ROW_MAX   = 9'd320;
    localparam logic [8:0]  ROW_MID   = 9'd160;
    localparam int          DVD_W     = 34;
    localparam int          ACC_W     = 36;

endpackage

// ----- rtl/core/touch_stroke_to_wavetable.sv -----
// Touch stroke to wavetable: top level with FSM, point list and wavetable memories.
// A completed point passes P1 to P5, a table read RD; press and lone samples give
// no result. Release reads each queued point (REL_RD, REL_GOT) and per drawn
// segment runs a slope division (one quotient bit a cycle), then fills inner
// columns in DRAW. One item at a time; input stalls until the current item's result
// is loaded. Reset (rst_n low, async) clears control state, then CLEAR zeroes the
// wavetable while input stalls; the config register is taken throughout.
module touch_stroke_to_wavetable #(
    parameter int TABLE_DEPTH = 512,
    parameter int LIST_DEPTH  = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic [11:0]        value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [8:0]         column,
    output logic [8:0]         row,
    output logic signed [17:0] level,
    output logic               touching,
    output logic               overflow
);

    localparam int TIDX_W = $clog2(TABLE_DEPTH);
    localparam int LIDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int DVD_W  = tstw_pkg::DVD_W;
    localparam int ACC_W  = tstw_pkg::ACC_W;

    function automatic logic [11:0] axis_off(input logic [11:0] v);
        logic [11:0] c;
        begin
            if (v < tstw_pkg::AXIS_MIN)
                c = tstw_pkg::AXIS_MIN;
            else if (v > tstw_pkg::AXIS_MAX)
                c = tstw_pkg::AXIS_MAX;
            else
                c = v;
            return c - tstw_pkg::AXIS_MIN;
        end
    endfunction

    // memories
    logic [17:0] table_mem [TABLE_DEPTH];
    logic [8:0]  pcol_mem  [LIST_DEPTH];
    logic [17:0] plvl_mem  [LIST_DEPTH];

    // control registers
    tstw_pkg::state_t state_reg, state_next;
    logic              direct_reg, direct_next;
    logic [11:0]       hf_reg, hf_next, hs_reg, hs_next;
    logic              hfv_reg, hfv_next, hsv_reg, hsv_next;
    logic [CNT_W-1:0]  count_reg, count_next, idx_reg, idx_next;
    logic              touch_reg, touch_next, drop_reg, drop_next;
    logic              cand_v_reg, cand_v_next, prev_v_reg, prev_v_next, fin_reg, fin_next;
    logic [5:0]        dcnt_reg, dcnt_next;
    logic [TIDX_W-1:0] clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;

    // datapath registers
    logic [11:0]       fy_reg, fy_next, sx_reg, sx_next;
    logic [32:0]       pr_reg;
    logic [33:0]       pc_reg;
    logic [8:0]        row_reg, col_reg;
    logic [18:0]       y_reg;
    logic              neg_reg;
    logic [36:0]       pl_reg;
    logic              rd_ok_reg, rd_ok_next;
    logic [8:0]        rd_idx_reg, rd_idx_next;
    logic [17:0]       tbl_q_reg;
    logic [8:0]        pq_col_reg;
    logic [17:0]       pq_lvl_reg;
    logic [8:0]        cand_col_reg, cand_col_next, kept_col_reg, kept_col_next;
    logic [8:0]        prev_col_reg, prev_col_next;
    logic [17:0]       cand_lvl_reg, cand_lvl_next, kept_lvl_reg, kept_lvl_next;
    logic [17:0]       prev_lvl_reg, prev_lvl_next;
    logic [8:0]        lo_col_reg, lo_col_next, hi_col_reg, hi_col_next, div_reg, div_next;
    logic [17:0]       lo_lvl_reg, lo_lvl_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [8:0]        rem_reg, rem_next;
    logic              sneg_reg, sneg_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [8:0]        cc_reg, cc_next;
    logic [1:0]        kind_reg;
    logic [8:0]        column_reg, row_out_reg;
    logic [17:0]       level_reg;
    logic              touching_reg, overflow_reg;

    // combinational
    logic              in_accept, slot_free, keep_done;
    logic              tw_en, pw_en, out_load;
    logic [TIDX_W-1:0] tw_addr, rd_addr;
    logic [17:0]       tw_data;
    logic [1:0]        ok_kind;
    logic [8:0]        ok_col, ok_row;
    logic [17:0]       ok_lvl;
    logic              ok_touch, ok_ovf;
    logic [15:0]       xr;
    logic [16:0]       xc, rr, rc;
    logic [8:0]        qr0, qr, row_calc;
    logic [9:0]        qc0, qc;
    logic [7:0]        absn;
    logic [16:0]       lq0, lmag;
    logic [18:0]       lr;
    logic [17:0]       lvl_calc;
    logic              last_pt, lt;
    logic [8:0]        lo_c, hi_c, width;
    logic [17:0]       lo_l, hi_l;
    logic signed [18:0] dl;
    logic [18:0]       dmag;
    logic [9:0]        tr;
    logic              ge;
    logic [ACC_W-1:0]  slope, acc_sum, acc_rnd;

    assign in_stall  = (state_reg != tstw_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign rd_addr   = ({1'b0, value} < 13'(TABLE_DEPTH)) ? TIDX_W'(value) : '0;

    // scale by constant 185: reciprocal estimate plus one correction
    assign xr       = {fy_reg, 4'b0};
    assign xc       = {1'b0, sx_reg, 4'b0} + {2'b0, sx_reg, 3'b0};
    assign qr0      = pr_reg[32:24];
    assign qc0      = pc_reg[33:24];
    assign rr       = 17'(xr) - 17'(qr0) * tstw_pkg::DIV_185;
    assign rc       = xc - 17'(qc0) * tstw_pkg::DIV_185;
    assign qr       = qr0 + 9'(rr >= tstw_pkg::DIV_185);
    assign qc       = qc0 + 10'(rc >= tstw_pkg::DIV_185);
    assign row_calc = tstw_pkg::ROW_MAX - qr;
    assign absn     = (row_reg > tstw_pkg::ROW_MID) ? 8'(row_reg - tstw_pkg::ROW_MID)
                                                     : 8'(tstw_pkg::ROW_MID - row_reg);
    assign lq0      = pl_reg[36:20];
    assign lr       = y_reg - 19'(lq0) * tstw_pkg::DIV_5;
    assign lmag     = lq0 + 17'(lr >= tstw_pkg::DIV_5);
    assign lvl_calc = neg_reg ? -18'(lmag) : 18'(lmag);

    // segment setup
    assign lt    = prev_col_reg < kept_col_reg;
    assign lo_c  = lt ? prev_col_reg : kept_col_reg;
    assign hi_c  = lt ? kept_col_reg : prev_col_reg;
    assign lo_l  = lt ? prev_lvl_reg : kept_lvl_reg;
    assign hi_l  = lt ? kept_lvl_reg : prev_lvl_reg;
    assign width = hi_c - lo_c;
    assign dl    = signed'({hi_l[17], hi_l}) - signed'({lo_l[17], lo_l});
    assign dmag  = dl[18] ? 19'(-dl) : 19'(dl);

    // restoring divider step
    assign tr = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge = tr >= {1'b0, div_reg};

    assign slope   = sneg_reg ? -ACC_W'(dvd_reg) : ACC_W'(dvd_reg);
    assign acc_sum = acc_reg + slope;
    assign acc_rnd = acc_sum + ACC_W'(32768);

    assign last_pt = (CNT_W'(idx_reg + 1'b1) == count_reg);

    always_comb
    begin
        state_next    = state_reg;
        direct_next   = cfg_write ? cfg_data : direct_reg;
        hf_next       = hf_reg;
        hs_next       = hs_reg;
        hfv_next      = hfv_reg;
        hsv_next      = hsv_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        touch_next    = touch_reg;
        drop_next     = drop_reg;
        cand_v_next   = cand_v_reg;
        prev_v_next   = prev_v_reg;
        fin_next      = fin_reg;
        dcnt_next     = dcnt_reg;
        clr_next      = clr_reg;
        fy_next       = fy_reg;
        sx_next       = sx_reg;
        rd_ok_next    = rd_ok_reg;
        rd_idx_next   = rd_idx_reg;
        cand_col_next = cand_col_reg;
        cand_lvl_next = cand_lvl_reg;
        kept_col_next = kept_col_reg;
        kept_lvl_next = kept_lvl_reg;
        prev_col_next = prev_col_reg;
        prev_lvl_next = prev_lvl_reg;
        lo_col_next   = lo_col_reg;
        hi_col_next   = hi_col_reg;
        lo_lvl_next   = lo_lvl_reg;
        div_next      = div_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        sneg_next     = sneg_reg;
        acc_next      = acc_reg;
        cc_next       = cc_reg;
        keep_done     = 1'b0;
        tw_en         = 1'b0;
        tw_addr       = '0;
        tw_data       = '0;
        pw_en         = 1'b0;
        out_load      = 1'b0;
        ok_kind       = tstw_pkg::KIND_POINT;
        ok_col        = '0;
        ok_row        = '0;
        ok_lvl        = '0;
        ok_touch      = touch_reg;
        ok_ovf        = drop_reg;

        unique case (state_reg)
            tstw_pkg::ST_CLEAR:
            begin
                tw_en    = 1'b1;
                tw_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == TIDX_W'(TABLE_DEPTH - 1))
                    state_next = tstw_pkg::ST_IDLE;
            end
            tstw_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (opcode)
                        tstw_pkg::OP_FIRST:
                        begin
                            if (hsv_reg)
                            begin
                                hfv_next   = 1'b0;
                                hsv_next   = 1'b0;
                                fy_next    = axis_off(value);
                                sx_next    = axis_off(hs_reg);
                                state_next = tstw_pkg::ST_P1;
                            end
                            else
                            begin
                                hf_next  = value;
                                hfv_next = 1'b1;
                            end
                        end
                        tstw_pkg::OP_SECOND:
                        begin
                            if (hfv_reg)
                            begin
                                hfv_next   = 1'b0;
                                hsv_next   = 1'b0;
                                fy_next    = axis_off(hf_reg);
                                sx_next    = axis_off(value);
                                state_next = tstw_pkg::ST_P1;
                            end
                            else
                            begin
                                hs_next  = value;
                                hsv_next = 1'b1;
                            end
                        end
                        tstw_pkg::OP_PRESS:
                            touch_next = 1'b1;
                        tstw_pkg::OP_RELEASE:
                        begin
                            idx_next    = '0;
                            cand_v_next = 1'b0;
                            prev_v_next = 1'b0;
                            fin_next    = 1'b0;
                            state_next  = (count_reg == '0) ? tstw_pkg::ST_REL_DONE
                                                            : tstw_pkg::ST_REL_RD;
                        end
                        tstw_pkg::OP_READ:
                        begin
                            rd_ok_next  = {1'b0, value} < 13'(TABLE_DEPTH);
                            rd_idx_next = value[8:0];
                            state_next  = tstw_pkg::ST_RD;
                        end
                        default:
                        begin
                            // drop unknown opcodes
                        end
                    endcase
                end
            end
            tstw_pkg::ST_P1: state_next = tstw_pkg::ST_P2;
            tstw_pkg::ST_P2: state_next = tstw_pkg::ST_P3;
            tstw_pkg::ST_P3: state_next = tstw_pkg::ST_P4;
            tstw_pkg::ST_P4: state_next = tstw_pkg::ST_P5;
            tstw_pkg::ST_P5:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    ok_kind  = tstw_pkg::KIND_POINT;
                    ok_col   = col_reg;
                    ok_row   = row_reg;
                    ok_lvl   = lvl_calc;
                    if (direct_reg)
                    begin
                        tw_en   = 32'(col_reg) < TABLE_DEPTH;
                        tw_addr = TIDX_W'(col_reg);
                        tw_data = lvl_calc;
                    end
                    else if (count_reg < CNT_W'(LIST_DEPTH))
                    begin
                        pw_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                        ok_ovf    = 1'b1;
                    end
                    state_next = tstw_pkg::ST_IDLE;
                end
            end
            tstw_pkg::ST_RD:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    ok_kind    = tstw_pkg::KIND_READ;
                    ok_col     = rd_idx_reg;
                    ok_lvl     = rd_ok_reg ? tbl_q_reg : '0;
                    state_next = tstw_pkg::ST_IDLE;
                end
            end
            tstw_pkg::ST_REL_RD:
                state_next = tstw_pkg::ST_REL_GOT;
            tstw_pkg::ST_REL_GOT:
            begin
                cand_col_next = pq_col_reg;
                cand_lvl_next = pq_lvl_reg;
                cand_v_next   = 1'b1;
                if (cand_v_reg && pq_col_reg != cand_col_reg)
                begin
                    kept_col_next = cand_col_reg;
                    kept_lvl_next = cand_lvl_reg;
                    state_next    = tstw_pkg::ST_KEEP;
                end
                else if (last_pt)
                begin
                    kept_col_next = pq_col_reg;
                    kept_lvl_next = pq_lvl_reg;
                    fin_next      = 1'b1;
                    state_next    = tstw_pkg::ST_KEEP;
                end
                else
                begin
                    // a later point with the same column replaces the candidate
                    idx_next   = idx_reg + 1'b1;
                    state_next = tstw_pkg::ST_REL_RD;
                end
            end
            tstw_pkg::ST_KEEP:
            begin
                if (!prev_v_reg)
                    keep_done = 1'b1;
                else
                begin
                    tw_en       = 32'(lo_c) < TABLE_DEPTH;
                    tw_addr     = TIDX_W'(lo_c);
                    tw_data     = lo_l;
                    lo_col_next = lo_c;
                    hi_col_next = hi_c;
                    lo_lvl_next = lo_l;
                    div_next    = width;
                    if (width <= 9'd1)
                        keep_done = 1'b1;
                    else
                    begin
                        dvd_next   = {dmag[17:0], 16'b0};
                        rem_next   = '0;
                        dcnt_next  = '0;
                        sneg_next  = dl[18];
                        state_next = tstw_pkg::ST_DIV;
                    end
                end
            end
            tstw_pkg::ST_DIV:
            begin
                dvd_next  = {dvd_reg[DVD_W-2:0], ge};
                rem_next  = ge ? 9'(tr - {1'b0, div_reg}) : tr[8:0];
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 6'(DVD_W - 1))
                begin
                    acc_next   = {{(ACC_W-34){lo_lvl_reg[17]}}, lo_lvl_reg, 16'b0};
                    cc_next    = lo_col_reg + 1'b1;
                    state_next = tstw_pkg::ST_DRAW;
                end
            end
            tstw_pkg::ST_DRAW:
            begin
                tw_en    = 32'(cc_reg) < TABLE_DEPTH;
                tw_addr  = TIDX_W'(cc_reg);
                tw_data  = acc_rnd[33:16];
                acc_next = acc_sum;
                cc_next  = cc_reg + 1'b1;
                if (9'(cc_reg + 1'b1) == hi_col_reg)
                    keep_done = 1'b1;
            end
            tstw_pkg::ST_REL_DONE:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    ok_kind    = tstw_pkg::KIND_DONE;
                    ok_touch   = 1'b0;
                    drop_next  = 1'b0;
                    count_next = '0;
                    touch_next = 1'b0;
                    state_next = tstw_pkg::ST_IDLE;
                end
            end
            default:
                state_next = tstw_pkg::ST_IDLE;
        endcase

        // a kept point becomes the start of the next segment
        if (keep_done)
        begin
            prev_col_next = kept_col_reg;
            prev_lvl_next = kept_lvl_reg;
            prev_v_next   = 1'b1;
            if (fin_reg)
                state_next = tstw_pkg::ST_REL_DONE;
            else if (last_pt)
            begin
                kept_col_next = cand_col_reg;
                kept_lvl_next = cand_lvl_reg;
                fin_next      = 1'b1;
                state_next    = tstw_pkg::ST_KEEP;
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = tstw_pkg::ST_REL_RD;
            end
        end

        if (out_load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tstw_pkg::ST_CLEAR;
            direct_reg    <= 1'b0;
            hf_reg        <= '0;
            hs_reg        <= '0;
            hfv_reg       <= 1'b0;
            hsv_reg       <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            touch_reg     <= 1'b1;
            drop_reg      <= 1'b0;
            cand_v_reg    <= 1'b0;
            prev_v_reg    <= 1'b0;
            fin_reg       <= 1'b0;
            dcnt_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            direct_reg    <= direct_next;
            hf_reg        <= hf_next;
            hs_reg        <= hs_next;
            hfv_reg       <= hfv_next;
            hsv_reg       <= hsv_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            touch_reg     <= touch_next;
            drop_reg      <= drop_next;
            cand_v_reg    <= cand_v_next;
            prev_v_reg    <= prev_v_next;
            fin_reg       <= fin_next;
            dcnt_reg      <= dcnt_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fy_reg       <= fy_next;
        sx_reg       <= sx_next;
        pr_reg       <= 33'(xr) * 33'(tstw_pkg::RECIP_185);
        pc_reg       <= 34'(xc) * 34'(tstw_pkg::RECIP_185);
        row_reg      <= row_calc;
        col_reg      <= qc[8:0];
        neg_reg      <= row_reg > tstw_pkg::ROW_MID;
        y_reg        <= {absn, 11'b0} + 19'd2;
        pl_reg       <= 37'(y_reg) * 37'(tstw_pkg::RECIP_5);
        rd_ok_reg    <= rd_ok_next;
        rd_idx_reg   <= rd_idx_next;
        cand_col_reg <= cand_col_next;
        cand_lvl_reg <= cand_lvl_next;
        kept_col_reg <= kept_col_next;
        kept_lvl_reg <= kept_lvl_next;
        prev_col_reg <= prev_col_next;
        prev_lvl_reg <= prev_lvl_next;
        lo_col_reg   <= lo_col_next;
        hi_col_reg   <= hi_col_next;
        lo_lvl_reg   <= lo_lvl_next;
        div_reg      <= div_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        sneg_reg     <= sneg_next;
        acc_reg      <= acc_next;
        cc_reg       <= cc_next;
        if (out_load)
        begin
            kind_reg     <= ok_kind;
            column_reg   <= ok_col;
            row_out_reg  <= ok_row;
            level_reg    <= ok_lvl;
            touching_reg <= ok_touch;
            overflow_reg <= ok_ovf;
        end
    end

    // wavetable: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (tw_en)
            table_mem[tw_addr] <= tw_data;
        if (in_accept)
            tbl_q_reg <= table_mem[rd_addr];
    end

    // point list
    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            pcol_mem[count_reg[LIDX_W-1:0]] <= col_reg;
            plvl_mem[count_reg[LIDX_W-1:0]] <= lvl_calc;
        end
        pq_col_reg <= pcol_mem[idx_reg[LIDX_W-1:0]];
        pq_lvl_reg <= plvl_mem[idx_reg[LIDX_W-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign column    = column_reg;
    assign row       = row_out_reg;
    assign level     = signed'(level_reg);
    assign touching  = touching_reg;
    assign overflow  = overflow_reg;

endmodule

// ----- rtl/core/tstw_check.sv -----
// Port-level checker for the touch stroke to wavetable block, with its bind.
module tstw_check (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [8:0]  column,
    input logic [8:0]  row,
    input logic [17:0] level,
    input logic        touching
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(level))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind == tstw_pkg::KIND_POINT || kind == tstw_pkg::KIND_DONE ||
                      kind == tstw_pkg::KIND_READ)
        else $error("bad result kind");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == tstw_pkg::KIND_DONE |-> !touching && row == '0 && level == '0)
        else $error("stroke end result malformed");

    a_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == tstw_pkg::KIND_POINT |-> row <= 9'd320 && column <= 9'd480)
        else $error("point out of screen range");

    a_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == tstw_pkg::KIND_READ |-> row == '0)
        else $error("read result carries a row");

endmodule

bind touch_stroke_to_wavetable tstw_check u_tstw_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind     (kind),
    .column   (column),
    .row      (row),
    .level    (level),
    .touching (touching)
);

// ----- tb/touch_stroke_to_wavetable_checker.sv -----
// Checker: watches both channels, predicts each result and compares it with the block's output.
module touch_stroke_to_wavetable_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic [11:0]        value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         kind,
    input  logic [8:0]         column,
    input  logic [8:0]         row,
    input  logic signed [17:0] level,
    input  logic               touching,
    input  logic               overflow,
    output int                 fails,
    output int                 pending
);

    localparam int TBL_DEPTH = 512;
    localparam int PT_DEPTH  = 1024;
    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic [1:0]         kind;
        logic [8:0]         column;
        logic [8:0]         row;
        logic signed [17:0] level;
        logic               touching;
        logic               overflow;
    } touch_result_t;

    touch_result_t      expected_results[EXP_DEPTH];
    int                 exp_wr;
    int                 exp_rd;
    int                 exp_cnt;
    logic               direct_mode;
    logic [11:0]        first_axis;
    logic               first_held;
    logic [11:0]        second_axis;
    logic               second_held;
    int                 pt_col[PT_DEPTH];
    int                 pt_lvl[PT_DEPTH];
    int                 pt_count;
    int                 wave[TBL_DEPTH];
    logic               touch_on;
    logic               lost_point;

    assign pending = exp_cnt;

    task automatic report(input string field, input int exp_v, input int got_v);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, field, exp_v, got_v);
        fails++;
    endtask

    function automatic int clamp_axis(input int v);
        return (v < 160) ? 160 : ((v > 3860) ? 3860 : v);
    endfunction

    function automatic void push_result(input logic [1:0] k, input int c, input int r,
                                        input int l);
        touch_result_t res;
        res.kind     = k;
        res.column   = c[8:0];
        res.row      = r[8:0];
        res.level    = l[17:0];
        res.touching = touch_on;
        res.overflow = lost_point;
        expected_results[exp_wr] = res;
        exp_wr = (exp_wr + 1) % EXP_DEPTH;
        exp_cnt++;
    endfunction

    function automatic void place_point(input int fa, input int sa);
        int fy, sx, r, c, n, mag, l;
        fy  = clamp_axis(fa);
        sx  = clamp_axis(sa);
        r   = 320 - (16 * (fy - 160)) / 185;
        c   = (24 * (sx - 160)) / 185;
        n   = 160 - r;
        mag = ((n < 0 ? -n : n) * 2048 + 2) / 5;
        l   = (n < 0) ? -mag : mag;
        if (direct_mode) begin
            if (c < TBL_DEPTH) wave[c] = l;
        end else if (pt_count < PT_DEPTH) begin
            pt_col[pt_count] = c;
            pt_lvl[pt_count] = l;
            pt_count++;
        end else begin
            lost_point = 1'b1;
        end
        push_result(tstw_pkg::KIND_POINT, c, r, l);
    endfunction

    function automatic void draw_line(input int lo, input int ylo, input int hi, input int yhi);
        longint acc, slope;
        if (lo < TBL_DEPTH) wave[lo] = ylo;
        if (hi <= lo) return;
        slope = (longint'(yhi) - longint'(ylo)) * 65536 / longint'(hi - lo);
        acc   = longint'(ylo) * 65536;
        for (int c = lo + 1; c < hi; c++) begin
            acc += slope;
            if (c < TBL_DEPTH) wave[c] = int'((acc + 32768) >>> 16);
        end
    endfunction

    function automatic void draw_stroke();
        int kept;
        kept = 0;
        for (int i = 0; i < pt_count; i++) begin
            // keep only the last point of a run of equal columns
            if (i + 1 < pt_count && pt_col[i] == pt_col[i + 1]) continue;
            pt_col[kept] = pt_col[i];
            pt_lvl[kept] = pt_lvl[i];
            kept++;
        end
        for (int i = 0; i + 1 < kept; i++) begin
            if (pt_col[i] < pt_col[i + 1])
                draw_line(pt_col[i], pt_lvl[i], pt_col[i + 1], pt_lvl[i + 1]);
            else
                draw_line(pt_col[i + 1], pt_lvl[i + 1], pt_col[i], pt_lvl[i]);
        end
        pt_count = 0;
    endfunction

    function automatic void predict(input logic [2:0] op, input logic [11:0] v);
        case (op)
            tstw_pkg::OP_FIRST: begin
                if (second_held) begin
                    first_held  = 1'b0;
                    second_held = 1'b0;
                    place_point(v, second_axis);
                end else begin
                    first_axis = v;
                    first_held = 1'b1;
                end
            end
            tstw_pkg::OP_SECOND: begin
                if (first_held) begin
                    first_held  = 1'b0;
                    second_held = 1'b0;
                    place_point(first_axis, v);
                end else begin
                    second_axis = v;
                    second_held = 1'b1;
                end
            end
            tstw_pkg::OP_PRESS: touch_on = 1'b1;
            tstw_pkg::OP_RELEASE: begin
                draw_stroke();
                touch_on = 1'b0;
                push_result(tstw_pkg::KIND_DONE, 0, 0, 0);
                lost_point = 1'b0;
            end
            tstw_pkg::OP_READ:
                push_result(tstw_pkg::KIND_READ, v, 0, (v < TBL_DEPTH) ? wave[v] : 0);
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n) begin
        touch_result_t res;
        if (!rst_n) begin
            fails       = 0;
            direct_mode = 1'b0;
            first_axis  = '0;
            first_held  = 1'b0;
            second_axis = '0;
            second_held = 1'b0;
            pt_count    = 0;
            touch_on    = 1'b1;
            lost_point  = 1'b0;
            for (int i = 0; i < TBL_DEPTH; i++) wave[i] = 0;
            exp_wr  = 0;
            exp_rd  = 0;
            exp_cnt = 0;
        end else begin
            if (cfg_write) direct_mode = cfg_data;
            if (in_valid && !in_stall) predict(opcode, value);
            if (out_valid && !out_stall) begin
                if (exp_cnt == 0) begin
                    report("unexpected transfer, kind", -1, kind);
                end else begin
                    res    = expected_results[exp_rd];
                    exp_rd = (exp_rd + 1) % EXP_DEPTH;
                    exp_cnt--;
                    if (kind !== res.kind) report("kind", res.kind, kind);
                    if (column !== res.column) report("column", res.column, column);
                    if (row !== res.row) report("row", res.row, row);
                    if (level !== res.level) report("level", res.level, level);
                    if (touching !== res.touching) report("touching", res.touching, touching);
                    if (overflow !== res.overflow) report("overflow", res.overflow, overflow);
                end
            end
        end
    end

endmodule

// ----- tb/touch_stroke_to_wavetable_tb.sv -----
// Testbench top: clock, reset, stimulus and verdict for the touch stroke to wavetable block.
module touch_stroke_to_wavetable_tb;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic               cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         opcode;
    logic [11:0]        value;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         kind;
    logic [8:0]         column;
    logic [8:0]         row;
    logic signed [17:0] level;
    logic               touching;
    logic               overflow;
    int                 fails;
    int                 pending;

    int                 send_idle_pct;
    int                 stall_pct;
    int                 hold_off;
    int                 sent;

    touch_stroke_to_wavetable uut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .value(value),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .column(column),
        .row(row), .level(level), .touching(touching), .overflow(overflow)
    );

    touch_stroke_to_wavetable_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .value(value),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .column(column),
        .row(row), .level(level), .touching(touching), .overflow(overflow),
        .fails(fails), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: random stall plus a counted hold-off
    always @(posedge clk)
    begin
        if (hold_off > 0) begin
            hold_off  <= hold_off - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    task automatic send(input logic [2:0] op, input logic [11:0] v);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    // drain and write the mode register while idle
    task automatic set_mode(input logic m);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (10) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [11:0] axis_value();
        case ($urandom_range(9, 0))
            0: return 12'($urandom_range(159, 0));
            1: return 12'($urandom_range(4095, 3861));
            default: return 12'($urandom_range(4095, 0));
        endcase
    endfunction

    task automatic send_point(input logic [11:0] fa, input logic [11:0] sa);
        if ($urandom_range(1, 0)) begin
            send(tstw_pkg::OP_FIRST, fa);
            send(tstw_pkg::OP_SECOND, sa);
        end else begin
            send(tstw_pkg::OP_SECOND, sa);
            send(tstw_pkg::OP_FIRST, fa);
        end
    endtask

    task automatic random_stroke();
        int npts;
        npts = $urandom_range(12, 1);
        if ($urandom_range(9, 0) != 0) send(tstw_pkg::OP_PRESS, 12'($urandom));
        for (int i = 0; i < npts; i++) begin
            if ($urandom_range(9, 0) == 0)
                send(3'($urandom), 12'($urandom));
            else
                send_point(axis_value(), axis_value());
        end
        if ($urandom_range(9, 0) != 0) send(tstw_pkg::OP_RELEASE, 12'($urandom));
        repeat ($urandom_range(3, 0)) begin
            if ($urandom_range(3, 0) == 0)
                send(tstw_pkg::OP_READ, 12'($urandom));
            else
                send(tstw_pkg::OP_READ, 12'($urandom_range(511, 0)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_data      = 1'b0;
        in_valid      = 1'b0;
        opcode        = tstw_pkg::OP_PRESS;
        value         = '0;
        hold_off      = 0;
        sent          = 0;
        send_idle_pct = 15;
        stall_pct     = 71;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_mode(1'b0);

        // directed: reads at the table edges, opcode extremes and clamping
        send(tstw_pkg::OP_READ, 12'd0);
        send(tstw_pkg::OP_READ, 12'd511);
        send(tstw_pkg::OP_READ, 12'd512);
        send(tstw_pkg::OP_READ, 12'd4095);
        send(3'd5, 12'd1);
        send(3'd7, 12'hFFF);
        send(tstw_pkg::OP_PRESS, 12'd0);
        send(tstw_pkg::OP_FIRST, 12'd0);
        send(tstw_pkg::OP_SECOND, 12'd4095);
        send(tstw_pkg::OP_SECOND, 12'd159);
        send(tstw_pkg::OP_SECOND, 12'd2000);
        send(tstw_pkg::OP_FIRST, 12'd3861);
        send_point(12'd2000, 12'd2001);
        send_point(12'd1000, 12'd2002);
        send(tstw_pkg::OP_FIRST, 12'd1234);
        send(tstw_pkg::OP_RELEASE, 12'd0);
        send(tstw_pkg::OP_READ, 12'd0);
        send(tstw_pkg::OP_READ, 12'd238);
        send(tstw_pkg::OP_RELEASE, 12'd0);
        send(3'd6, 12'd0);
        set_mode(1'b1);
        send_point(12'd3860, 12'd3860);
        send(tstw_pkg::OP_READ, 12'd480);
        set_mode(1'b0);

        // a longer stroke, mostly on one column with a few jumps
        send(tstw_pkg::OP_PRESS, 12'd0);
        for (int i = 0; i < 40; i++)
            send_point(axis_value(), (i % 8 == 0) ? axis_value() : 12'd2000);
        send(tstw_pkg::OP_RELEASE, 12'd0);
        // drain, then hold off the receiver while reads keep coming so the block backs up
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        hold_off = 300;
        for (int i = 0; i < 4; i++)
            send(tstw_pkg::OP_READ, 12'($urandom_range(511, 0)));

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : ((ph == 1) ? 71 : 0);
            stall_pct     = (ph == 0) ? 71 : ((ph == 1) ? 15 : 0);
            set_mode(ph == 1);
            for (int k = 0; k < 440; ) begin
                int before_count;
                before_count = sent;
                random_stroke();
                k += sent - before_count;
                if ($urandom_range(7, 0) == 0) set_mode($urandom_range(1, 0));
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
